### rtl/twkm_pkg.sv
// Package for the text width kerning measure unit.
// Holds shared constants, input function codes, controller state encoding,
// command and status structs and the saturation helper.
package twkm_pkg;

  localparam int GlyphCount  = 1024;
  localparam int KernSlots   = 8;
  localparam int InDataW     = 120;
  localparam int OutDataW    = 128;
  localparam int CfgDataW    = 15;
  localparam logic [7:0] SpaceCode = 8'd32;
  localparam logic [14:0] SizeReset = 15'd240;

  typedef enum logic [1:0] {
    FUNC_MAP     = 2'd0,
    FUNC_METRIC  = 2'd1,
    FUNC_KERN    = 2'd2,
    FUNC_MEASURE = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    CFG_SIZE = 1'b0,
    CFG_KERN = 1'b1
  } cfg_idx_t;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_LOAD   = 10'b0000000100,
    ST_MAPRD  = 10'b0000001000,
    ST_MAPCHK = 10'b0000010000,
    ST_SPCCHK = 10'b0000100000,
    ST_KERN   = 10'b0001000000,
    ST_ACC    = 10'b0010000000,
    ST_SCALE  = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic clr_wr;
    logic map_rd;
    logic map_space;
    logic raw_latch;
    logic take_glyph;
    logic fail;
    logic kern_step;
    logic acc;
    logic scale_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic map_ok;
    logic pending;
    logic kern_done;
    logic failed;
    logic last;
    logic scale_done;
    logic out_busy;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/twkm_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module twkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/twkm_div.sv
// Scaling unit: (size * value + 500) / 1000 toward zero, saturated to 32 bits.
// A multiply by the size, then the divide by 1000 as a reciprocal multiplication
// in four 21 by 21 partial products. Uses twkm_pkg.
module twkm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [14:0]        size,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] quot
);

  // ceil(2^51 / 1000): exact quotient for every magnitude below SatLimit
  localparam logic [41:0] Recip    = 42'h20C_49BA_5E36;
  localparam logic [47:0] SatLimit = 48'd2147483648000;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ABS  = 4'b0010,
    PH_MUL  = 4'b0100,
    PH_OUT  = 4'b1000
  } phase_t;

  phase_t             phase;
  logic signed [47:0] prod;
  logic signed [47:0] rounded;
  logic [47:0]        mag;
  logic [41:0]        num;
  logic               neg;
  logic               big;
  logic [1:0]         cnt;
  logic [20:0]        pp_a;
  logic [20:0]        pp_b;
  logic [41:0]        pp;
  logic [83:0]        pp_ext;
  logic [83:0]        acc;
  logic [31:0]        q;

  assign rounded = prod + 48'sd500;
  assign mag     = rounded[47] ? 48'(-rounded) : 48'(rounded);
  assign pp_a    = cnt[0] ? num[41:21] : num[20:0];
  assign pp_b    = cnt[1] ? Recip[41:21] : Recip[20:0];
  assign pp      = 42'(pp_a) * 42'(pp_b);
  assign q       = acc[82:51];

  // align the partial product to its weight
  always_comb begin
    unique case (cnt)
      2'd0:    pp_ext = {42'd0, pp};
      2'd3:    pp_ext = {pp, 42'd0};
      default: pp_ext = {21'd0, pp, 21'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            prod  <= $signed({1'b0, size}) * value;
            phase <= PH_ABS;
          end
        end
        PH_ABS: begin
          neg   <= rounded[47];
          big   <= mag >= SatLimit;
          num   <= mag[41:0];
          acc   <= '0;
          cnt   <= '0;
          phase <= PH_MUL;
        end
        PH_MUL: begin
          acc <= acc + pp_ext;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) phase <= PH_OUT;
        end
        PH_OUT: begin
          if (big) quot <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          else quot <= neg ? -$signed(q) : $signed(q);
          done  <= 1'b1;
          phase <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

### rtl/twkm_ctrl.sv
// Controller state machine of the measure unit.
// Sequences kern slot clearing after reset, table loads, map lookup, kern
// search, accumulate, scaling and result transfer. Uses twkm_pkg.
module twkm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_func,
  output logic               in_ready,
  input  twkm_pkg::sts_t     sts,
  output twkm_pkg::cmd_t     cmd
);

  twkm_pkg::state_t state, state_next;

  assign in_ready = (state == twkm_pkg::ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      twkm_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = twkm_pkg::ST_IDLE;
      end
      twkm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = (twkm_pkg::func_t'(in_func) == twkm_pkg::FUNC_MEASURE) ?
                       twkm_pkg::ST_MAPRD : twkm_pkg::ST_LOAD;
        end
      end
      twkm_pkg::ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = twkm_pkg::ST_IDLE;
      end
      twkm_pkg::ST_MAPRD: begin
        if (sts.failed) begin
          state_next = sts.last ? twkm_pkg::ST_EMIT : twkm_pkg::ST_IDLE;
        end else begin
          cmd.map_rd = 1'b1;
          state_next = twkm_pkg::ST_MAPCHK;
        end
      end
      twkm_pkg::ST_MAPCHK: begin
        cmd.raw_latch = 1'b1;
        if (sts.map_ok) begin
          cmd.take_glyph = 1'b1;
          state_next = sts.pending ? twkm_pkg::ST_KERN : twkm_pkg::ST_ACC;
        end else begin
          cmd.map_rd    = 1'b1;
          cmd.map_space = 1'b1;
          state_next    = twkm_pkg::ST_SPCCHK;
        end
      end
      twkm_pkg::ST_SPCCHK: begin
        if (sts.map_ok) begin
          cmd.take_glyph = 1'b1;
          state_next = sts.pending ? twkm_pkg::ST_KERN : twkm_pkg::ST_ACC;
        end else begin
          cmd.fail   = 1'b1;
          state_next = sts.last ? twkm_pkg::ST_EMIT : twkm_pkg::ST_IDLE;
        end
      end
      twkm_pkg::ST_KERN: begin
        cmd.kern_step = 1'b1;
        if (sts.kern_done) state_next = twkm_pkg::ST_ACC;
      end
      twkm_pkg::ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? twkm_pkg::ST_SCALE : twkm_pkg::ST_IDLE;
      end
      twkm_pkg::ST_SCALE: begin
        cmd.scale_step = 1'b1;
        if (sts.scale_done) state_next = twkm_pkg::ST_EMIT;
      end
      twkm_pkg::ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = twkm_pkg::ST_IDLE;
        end
      end
      default: state_next = twkm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= twkm_pkg::ST_CLEAR;
    else state <= state_next;
  end

endmodule

### rtl/twkm_dp.sv
// Datapath of the measure unit: tables, accumulators, scaling and the
// output register. Uses twkm_pkg, twkm_ram and twkm_div.
module twkm_dp #(
  parameter int GLYPH_COUNT = twkm_pkg::GlyphCount,
  parameter int KERN_SLOTS  = twkm_pkg::KernSlots
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [twkm_pkg::InDataW-1:0]  s_tdata,
  input  logic [1:0]                    s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [twkm_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tuser,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [twkm_pkg::CfgDataW-1:0] cfg_data,
  input  twkm_pkg::cmd_t                cmd,
  output twkm_pkg::sts_t                sts
);

  localparam int GW   = $clog2(GLYPH_COUNT);
  localparam int KD   = GLYPH_COUNT * KERN_SLOTS;
  localparam int KAW  = $clog2(KD);
  localparam int KJW  = $clog2(KERN_SLOTS + 1);

  logic [14:0] size_twips;
  logic        kerning_on;

  twkm_pkg::func_t    func;
  logic [7:0]         code;
  logic signed [10:0] glyph;
  logic [63:0]        metric_in;
  logic [2:0]         slot;
  logic signed [10:0] kern_glyph;
  logic signed [15:0] kern_adjust;
  logic               last;
  logic               glyph_ok;
  logic               slot_ok;

  logic [255:0]       map_vld;
  logic               map_vq;
  logic [10:0]        map_rdata;
  logic [7:0]         map_raddr;
  logic               map_ok;

  logic [63:0]        met_rdata;
  logic [26:0]        kern_rdata;
  logic               kern_we;
  logic [KAW-1:0]     kern_waddr;
  logic [26:0]        kern_wdata;
  logic [KAW-1:0]     kern_raddr;
  logic               kern_re;
  logic [KAW-1:0]     clr_cnt;

  logic signed [10:0] raw;
  logic [GW-1:0]      gidx;
  logic               g_space;
  logic               pending;
  logic [GW-1:0]      pend_idx;
  logic [KJW-1:0]     kj;
  logic               kchk;
  logic               hit;
  logic               kj_end;

  logic signed [31:0] units;
  logic signed [31:0] right_edge;
  logic signed [15:0] max_top;
  logic signed [15:0] max_bottom;
  logic               failed;

  logic signed [15:0] m_adv, m_top, m_bot, m_rgt;

  logic [2:0]         sk;
  logic               inflight;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] div_val;
  logic [31:0]        res [4];

  assign glyph_ok = !glyph[10] && (32'(glyph) < GLYPH_COUNT);
  assign slot_ok  = 32'(slot) < KERN_SLOTS;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_twips <= twkm_pkg::SizeReset;
      kerning_on <= 1'b0;
    end else if (cfg_we) begin
      unique case (twkm_pkg::cfg_idx_t'(cfg_addr))
        twkm_pkg::CFG_SIZE: size_twips <= cfg_data;
        twkm_pkg::CFG_KERN: kerning_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func        <= twkm_pkg::func_t'(s_tuser);
      code        <= s_tdata[7:0];
      glyph       <= s_tdata[18:8];
      metric_in   <= s_tdata[82:19];
      slot        <= s_tdata[85:83];
      kern_glyph  <= s_tdata[96:86];
      kern_adjust <= s_tdata[112:97];
      last        <= s_tlast;
    end
  end

  // code map
  assign map_raddr = cmd.map_space ? twkm_pkg::SpaceCode : code;
  assign map_ok    = map_vq && !map_rdata[10];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
    end else if (cmd.load_wr && func == twkm_pkg::FUNC_MAP) begin
      map_vld[code] <= 1'b1;
    end
    if (cmd.map_rd) map_vq <= map_vld[map_raddr];
  end

  twkm_ram #(.WIDTH(11), .DEPTH(256)) u_map (
    .clk  (clk),
    .we   (cmd.load_wr && func == twkm_pkg::FUNC_MAP),
    .waddr(code),
    .wdata(glyph_ok ? glyph : 11'h7FF),
    .re   (cmd.map_rd),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  twkm_ram #(.WIDTH(64), .DEPTH(GLYPH_COUNT)) u_met (
    .clk  (clk),
    .we   (cmd.load_wr && func == twkm_pkg::FUNC_METRIC && glyph_ok),
    .waddr(GW'(glyph[9:0])),
    .wdata(metric_in),
    .re   (cmd.take_glyph),
    .raddr(GW'(map_rdata[9:0])),
    .rdata(met_rdata)
  );

  assign {m_rgt, m_bot, m_top, m_adv} = met_rdata;

  // kern slots, cleared after reset
  assign kern_we    = cmd.clr_wr ||
                      (cmd.load_wr && func == twkm_pkg::FUNC_KERN && glyph_ok && slot_ok);
  assign kern_waddr = cmd.clr_wr ? clr_cnt :
                      KAW'(KAW'(glyph[9:0]) * KAW'(KERN_SLOTS) + KAW'(slot));
  assign kern_wdata = cmd.clr_wr ? {16'sd0, 11'h7FF} : {kern_adjust, kern_glyph};
  assign kern_raddr = KAW'(KAW'(pend_idx) * KAW'(KERN_SLOTS) + KAW'(kj));
  assign kj_end     = kj == KJW'(KERN_SLOTS);
  assign hit        = kchk && !kern_rdata[10] && ($signed(kern_rdata[10:0]) == raw);
  assign kern_re    = cmd.kern_step && !hit && !kj_end;

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_wr) clr_cnt <= clr_cnt + KAW'(1);
  end

  twkm_ram #(.WIDTH(27), .DEPTH(KD)) u_kern (
    .clk  (clk),
    .we   (kern_we),
    .waddr(kern_waddr),
    .wdata(kern_wdata),
    .re   (kern_re),
    .raddr(kern_raddr),
    .rdata(kern_rdata)
  );

  // glyph selection and kern search
  always_ff @(posedge clk) begin
    if (cmd.raw_latch) raw <= map_ok ? $signed(map_rdata) : -11'sd1;
    if (cmd.take_glyph) begin
      gidx    <= GW'(map_rdata[9:0]);
      g_space <= map_rdata == 11'(twkm_pkg::SpaceCode);
      kj      <= '0;
      kchk    <= 1'b0;
    end else if (cmd.kern_step) begin
      kchk <= kern_re;
      if (kern_re) kj <= kj + KJW'(1);
    end
  end

  // run accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      units      <= '0;
      right_edge <= '0;
      max_top    <= '0;
      max_bottom <= '0;
      pending    <= 1'b0;
      failed     <= 1'b0;
    end else begin
      if (cmd.fail) begin
        failed  <= 1'b1;
        pending <= 1'b0;
      end
      if (cmd.kern_step && hit) begin
        units <= twkm_pkg::sat32(33'(units) + 33'($signed(kern_rdata[26:11])));
      end
      if (cmd.acc) begin
        if (m_top > max_top) max_top <= m_top;
        if (m_bot > max_bottom) max_bottom <= m_bot;
        units <= twkm_pkg::sat32(33'(units) + 33'(m_adv));
        if (!g_space) right_edge <= twkm_pkg::sat32(33'(units) + 33'(m_rgt));
        pending  <= kerning_on && !last;
        pend_idx <= gidx;
      end
    end
  end

  // scaling of the four results through one shared unit
  always_comb begin
    unique case (sk[1:0])
      2'd0:    div_val = units;
      2'd1:    div_val = 32'(max_top);
      2'd2:    div_val = 32'(max_bottom);
      default: div_val = right_edge;
    endcase
  end

  assign div_start = cmd.scale_step && !inflight && !sk[2];

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      sk       <= '0;
      inflight <= 1'b0;
    end else begin
      if (div_start) inflight <= 1'b1;
      if (div_done) begin
        res[sk[1:0]] <= div_q;
        sk           <= sk + 3'd1;
        inflight     <= 1'b0;
      end
    end
  end

  twkm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .size (size_twips),
    .value(div_val),
    .done (div_done),
    .quot (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.emit) begin
      m_tuser <= failed;
      m_tdata <= failed ? '0 : {res[3], res[2], res[1], res[0]};
    end
  end

  assign sts.clr_last   = clr_cnt == KAW'(KD - 1);
  assign sts.map_ok     = map_ok;
  assign sts.pending    = pending;
  assign sts.kern_done  = hit || kj_end;
  assign sts.failed     = failed;
  assign sts.last       = last;
  assign sts.scale_done = sk[2];
  assign sts.out_busy   = m_tvalid && !m_tready;

endmodule

### rtl/text_width_kerning_measure_unit.sv
// Top level of the text width kerning measure unit.
// Joins the controller (twkm_ctrl) and the datapath (twkm_dp). Uses twkm_pkg.
//
// After reset the unit sweeps the kern slot memory with s_tready low;
// configuration writes are taken throughout. When a glyph is pending for
// kerning, a measured byte searches the kern slot memory, read one slot per
// cycle; a byte that falls back to the space glyph takes a second map read.
// After the last byte of a string that has not failed, the four results pass
// one at a time through a shared unit that multiplies by the size and
// divides by 1000 as a reciprocal multiplication in four partial products;
// then the output register is loaded. Configuration is to be written only
// while no string is in progress; the unit itself does not enforce this.
module text_width_kerning_measure_unit #(
  parameter int GLYPH_COUNT = twkm_pkg::GlyphCount,
  parameter int KERN_SLOTS  = twkm_pkg::KernSlots
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // code, glyph, advance, box_top, box_bottom, box_right, slot, kern_glyph,
  // kern_adjust
  input  logic [twkm_pkg::InDataW-1:0]  s_tdata,
  // func
  input  logic [1:0]                    s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // width, extent_top, extent_bottom, extent_right
  output logic [twkm_pkg::OutDataW-1:0] m_tdata,
  // status
  output logic                          m_tuser,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [twkm_pkg::CfgDataW-1:0] cfg_data
);

  twkm_pkg::cmd_t cmd;
  twkm_pkg::sts_t sts;

  twkm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_func (s_tuser),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  twkm_dp #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .KERN_SLOTS (KERN_SLOTS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

### rtl/twkm_checker.sv
// Port-level checks of the text width kerning measure unit, bound to the
// top level. Uses twkm_pkg.
module twkm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [twkm_pkg::InDataW-1:0]  s_tdata,
  input logic [1:0]                    s_tuser,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [twkm_pkg::OutDataW-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          cfg_we,
  input logic                          cfg_addr,
  input logic [twkm_pkg::CfgDataW-1:0] cfg_data
);

  a_rst_no_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result presented right after reset");

  a_rst_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during kern slot clearing");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("failed result carries nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind text_width_kerning_measure_unit twkm_checker u_twkm_checker (.*);

### test/tb_text_width_kerning_measure_unit.sv
`timescale 1ns / 100ps
// Testbench for text_width_kerning_measure_unit: table loads and string
// measurement, checked against a behavioral predictor. Depends on twkm_pkg.
module tb_text_width_kerning_measure_unit;
  import twkm_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int RandItems  = 400;
  localparam int NumPhases  = 5;

  typedef struct {
    func_t              func;
    logic [7:0]         code;
    logic signed [10:0] glyph;
    logic signed [15:0] adv, top, bot, rgt;
    logic [2:0]         slot;
    logic signed [10:0] kglyph;
    logic signed [15:0] kadj;
    logic               last;
  } text_item_t;

  typedef struct {
    logic        status;
    logic [31:0] width, top, bottom, right;
  } extent_t;

  typedef struct {
    text_item_t it;
    bit         typed;
    extent_t    res;
  } dir_row_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, s_tlast = 0;
  logic [InDataW-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0, m_tuser;
  logic [OutDataW-1:0] m_tdata;
  logic cfg_we = 0, cfg_addr = 0;
  logic [CfgDataW-1:0] cfg_data = '0;

  text_width_kerning_measure_unit i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic signed [10:0] code_glyph [256];
  logic signed [15:0] g_adv [GlyphCount], g_top [GlyphCount];
  logic signed [15:0] g_bot [GlyphCount], g_rgt [GlyphCount];
  bit                 g_loaded [GlyphCount];
  logic signed [10:0] pair_to [GlyphCount][KernSlots];
  logic signed [15:0] pair_adj [GlyphCount][KernSlots];
  longint run_width, run_prev, run_right, run_top, run_bot;
  int     pend_glyph;
  bit     run_failed;
  int     size_cur;
  bit     kern_cur;

  extent_t extent_q[$];
  int errors = 0, n_items = 0, n_results = 0, n_fail = 0, cycles = 0;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] to_points(input longint v);
    longint r;
    r = (longint'(size_cur) * v + 500) / 1000;
    return 32'(clip32(r));
  endfunction

  task automatic clear_run();
    run_width = 0; run_prev = 0; run_right = 0; run_top = 0; run_bot = 0;
    pend_glyph = -1; run_failed = 0;
  endtask

  task automatic measure_byte(input text_item_t it, output bit done, output extent_t r);
    int raw, g;
    bit hit;
    raw = code_glyph[it.code];
    g = raw;
    done = 0;
    hit = 0;
    if (!run_failed) begin
      if (g < 0) g = code_glyph[SpaceCode];
      if (g < 0) begin
        run_failed = 1;
        pend_glyph = -1;
      end else begin
        if (pend_glyph >= 0) begin
          for (int j = 0; j < KernSlots; j++) begin
            if (!hit && pair_to[pend_glyph][j] >= 0 && pair_to[pend_glyph][j] == raw) begin
              run_width = clip32(run_width + pair_adj[pend_glyph][j]);
              hit = 1;
            end
          end
        end
        if (run_top < g_top[g]) run_top = g_top[g];
        if (run_bot < g_bot[g]) run_bot = g_bot[g];
        run_prev = run_width;
        run_width = clip32(run_width + g_adv[g]);
        if (g != SpaceCode) run_right = clip32(run_prev + g_rgt[g]);
        pend_glyph = (kern_cur && !it.last) ? g : -1;
      end
    end
    if (it.last) begin
      done = 1;
      if (run_failed) r = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0};
      else r = '{1'b0, to_points(run_width), to_points(run_top),
                 to_points(run_bot), to_points(run_right)};
      clear_run();
    end
  endtask

  task automatic predict_text(input text_item_t it, output bit done, output extent_t r);
    bit ok;
    ok = it.glyph >= 0;
    done = 0;
    case (it.func)
      FUNC_MAP: begin
        code_glyph[it.code] = ok ? it.glyph : -11'sd1;
      end
      FUNC_METRIC: begin
        if (ok) begin
          g_adv[it.glyph] = it.adv; g_top[it.glyph] = it.top;
          g_bot[it.glyph] = it.bot; g_rgt[it.glyph] = it.rgt;
          g_loaded[it.glyph] = 1;
        end
      end
      FUNC_KERN: begin
        if (ok) begin
          pair_to[it.glyph][it.slot] = it.kglyph;
          pair_adj[it.glyph][it.slot] = it.kadj;
        end
      end
      default: measure_byte(it, done, r);
    endcase
  endtask

  function automatic text_item_t mk(input func_t f, input int code, input int glyph,
                                    input int adv, input int top, input int bot,
                                    input int rgt, input int slot, input int kg,
                                    input int kadj, input bit last);
    text_item_t it;
    it = '{f, 8'(code), 11'(glyph), 16'(adv), 16'(top), 16'(bot), 16'(rgt),
           3'(slot), 11'(kg), 16'(kadj), last};
    return it;
  endfunction

  // sender: bursts of transfers separated by random gaps unless no_gaps is set
  int burst_left = 0;
  bit no_gaps = 0;

  task automatic send_text(input text_item_t it, input bit typed, input extent_t tr);
    bit done;
    extent_t r;
    s_tvalid <= 1;
    s_tdata <= InDataW'({it.kadj, it.kglyph, it.slot, it.rgt, it.bot, it.top,
                         it.adv, it.glyph, it.code});
    s_tuser <= it.func;
    s_tlast <= it.last;
    do @(posedge clk); while (!s_tready);
    predict_text(it, done, r);
    if (done) extent_q.push_back(typed ? tr : r);
    n_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      if (!no_gaps && $urandom_range(0, 2) != 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // receiver: random stall modes, results checked against the expected queue
  int stall_mode = 0;
  always @(posedge clk) begin
    extent_t e, a;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("** text_width_kerning_measure_unit: FAILED **");
      $finish;
    end
    if (cycles % 400 == 0) stall_mode <= $urandom_range(0, 2);
    if (!rst && m_tvalid && m_tready) begin
      a = '{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96]};
      n_results++;
      if (a.status) n_fail++;
      if (extent_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d width=%0d", $time, a.status,
                 $signed(a.width));
        errors++;
      end else begin
        e = extent_q.pop_front();
        if (e.status !== a.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, a.status); errors++;
        end
        if (e.width !== a.width) begin
          $display("%0t: width exp %0d got %0d", $time, $signed(e.width),
                   $signed(a.width)); errors++;
        end
        if (e.top !== a.top) begin
          $display("%0t: extent_top exp %0d got %0d", $time, $signed(e.top),
                   $signed(a.top)); errors++;
        end
        if (e.bottom !== a.bottom) begin
          $display("%0t: extent_bottom exp %0d got %0d", $time, $signed(e.bottom),
                   $signed(a.bottom)); errors++;
        end
        if (e.right !== a.right) begin
          $display("%0t: extent_right exp %0d got %0d", $time, $signed(e.right),
                   $signed(a.right)); errors++;
        end
      end
    end
    case (stall_mode)
      0: m_tready <= 1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_cfg(input int size, input bit kern);
    cfg_we <= 1; cfg_addr <= CFG_SIZE; cfg_data <= CfgDataW'(size);
    @(posedge clk);
    cfg_addr <= CFG_KERN; cfg_data <= CfgDataW'(kern);
    @(posedge clk);
    cfg_we <= 0;
    size_cur = size;
    kern_cur = kern;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (extent_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic int pick_glyph();
    int p;
    p = $urandom_range(0, 17);
    return (p < 16) ? p : (p == 16 ? 32 : 1023);
  endfunction

  function automatic int pick_code();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(28, 45);
  endfunction

  function automatic text_item_t rand_text();
    int k, g;
    text_item_t it;
    it = mk(FUNC_MEASURE, pick_code(), 0, $urandom, $urandom, $urandom, $urandom,
            $urandom_range(0, 7), pick_glyph(), $urandom, $urandom_range(0, 4) == 0);
    k = $urandom_range(0, 99);
    if (k < 15) begin
      it.func = FUNC_MAP;
      g = pick_glyph();
      if ($urandom_range(0, 7) == 0) it.glyph = -11'($urandom_range(1, 1024));
      else it.glyph = g_loaded[g] ? 11'(g) : -11'sd1;
    end else if (k < 27) begin
      it.func = FUNC_METRIC;
      it.glyph = ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'(pick_glyph());
    end else if (k < 40) begin
      it.func = FUNC_KERN;
      it.glyph = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'(pick_glyph());
      if ($urandom_range(0, 5) == 0) it.kglyph = 11'($urandom);
    end else begin
      it.glyph = 11'($urandom);
    end
    return it;
  endfunction

  dir_row_t dir_rows[$];
  extent_t no_res, fail_res;

  initial begin
    for (int i = 0; i < 256; i++) code_glyph[i] = -11'sd1;
    for (int g = 0; g < GlyphCount; g++) begin
      g_loaded[g] = 0;
      for (int j = 0; j < KernSlots; j++) begin
        pair_to[g][j] = -11'sd1;
        pair_adj[g][j] = 0;
      end
    end
    clear_run();
    size_cur = SizeReset;
    kern_cur = 0;
    no_res = '{0, 0, 0, 0, 0};
    fail_res = '{1, 0, 0, 0, 0};

    // nothing mapped yet: a lone byte reports an error
    dir_rows.push_back('{mk(FUNC_MEASURE, 65, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, fail_res});
    dir_rows.push_back('{mk(FUNC_METRIC, 0, 5, 32767, 32767, -32768, 32767, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_METRIC, 0, 32, -32768, -32768, 32767, -32768, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_METRIC, 0, 1023, 100, 700, -200, 90, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_METRIC, 0, -5, 1, 1, 1, 1, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MAP, 255, 5, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MAP, 32, 32, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MAP, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MAP, 7, -1024, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_KERN, 0, 5, 0, 0, 0, 0, 0, -2, 5, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_KERN, 0, 5, 0, 0, 0, 0, 7, 1023, -32768, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_KERN, 0, 1023, 0, 0, 0, 0, 0, 5, 32767, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_KERN, 0, -1, 0, 0, 0, 0, 3, 5, 9, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MEASURE, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MEASURE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MEASURE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MEASURE, 255, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MEASURE, 32, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, no_res});
    // space unmapped: failure mid string, later bytes ignored
    dir_rows.push_back('{mk(FUNC_MAP, 32, -1, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MEASURE, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MEASURE, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});
    dir_rows.push_back('{mk(FUNC_MEASURE, 255, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, fail_res});
    dir_rows.push_back('{mk(FUNC_MAP, 32, 32, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_res});

    repeat (7) @(posedge clk);
    rst <= 0;
    write_cfg(32767, 1);
    foreach (dir_rows[i]) send_text(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: write_cfg(1, 1);
        1: write_cfg(240, 0);
        2: write_cfg(32767, 0);
        3: write_cfg(1000, 1);
        default: write_cfg($urandom_range(1, 32767), $urandom_range(0, 1));
      endcase
      no_gaps = (p == 2);
      for (int n = 0; n < RandItems; n++) send_text(rand_text(), 0, no_res);
      send_text(mk(FUNC_MEASURE, pick_code(), 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, no_res);
      drain();
    end

    $display("%0d transfers in, %0d results out (%0d error status), %0d cycles",
             n_items, n_results, n_fail, cycles);
    if (errors == 0) begin
      $display("** text_width_kerning_measure_unit: PASSED **");
    end else begin
      $display("** text_width_kerning_measure_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/twkm_pkg.sv
rtl/twkm_ram.sv
rtl/twkm_div.sv
rtl/twkm_ctrl.sv
rtl/twkm_dp.sv
rtl/text_width_kerning_measure_unit.sv
rtl/twkm_checker.sv
test/tb_text_width_kerning_measure_unit.sv
